// ===== rtl/nfb_pkg.sv =====
// Package: opcodes, status codes and register indexes for the nibble framebuffer.
`default_nettype none
package nfb_pkg;
  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_FILL  = 3'd1;
  localparam logic [2:0] OP_CHECK = 3'd2;
  localparam logic [2:0] OP_REDRAW = 3'd3;
  localparam logic [2:0] OP_SCAN  = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_CELL  = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SIDE = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_ROWS = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/nibble_framebuffer_dirty_scan_top.sv =====
// Top level: nibble framebuffer with dirty marks and a scan of dirty cells.
// One request at a time. Set pixel forms y*cells_per_row by repeated
// addition, then does three nibble read-modify-writes, each a read state
// and a write state on the cell memory, and marks the cell dirty where a
// nibble changes; a cell beyond the buffer ends it with an overflow status.
// Fill and checkerboard write one cell per cycle over the whole buffer;
// force redraw reads each cell and then marks it dirty if it is nonzero or
// force_all is set. Scan next first counts from cell 0 up to its pointer,
// one cell per cycle, then reads, checks and steps past every cell it
// skips; the first scan of a pass first fetches cell 0 in S_SC0 and S_SC0W.
// The dirty marks sit in a second memory; after reset a clearing pass over
// all MAX_CELLS marks zeroes them while requests are held off (configuration
// writes are taken throughout). The row and column of a cell are tracked as
// counters, so no divider is needed. The result sits in output registers
// and the next request is taken only once it has been accepted, so no
// request is taken in the cycle in which a result is accepted.
`default_nettype none
module nibble_framebuffer_dirty_scan_top #(
  parameter int MAX_SIDE  = 64,
  parameter int MAX_CELLS = 6144
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire [1:0]  cfg_index_i,
  input  wire [7:0]  cfg_data_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire [2:0]  opcode_i,
  input  wire [5:0]  pixel_x_i,
  input  wire [5:0]  pixel_y_i,
  input  wire [3:0]  color_a_i,
  input  wire [3:0]  color_b_i,
  input  wire        force_all_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [1:0] status_o,
  output logic [6:0] cell_col_o,
  output logic [5:0] cell_row_o,
  output logic [7:0] cell_color_o,
  output logic       cursor_jump_o,
  output logic       color_change_o
);
  import nfb_pkg::*;

  localparam int AW = $clog2(MAX_CELLS);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = $clog2((3 * MAX_SIDE + 1) / 2 + 1);
  localparam int PW = 10; // 3*x+2 for 6-bit x

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_SRD = 4'd2, S_SWR = 4'd3,
                         S_FILL = 4'd4, S_RRD = 4'd5, S_RWR = 4'd6, S_SC0 = 4'd7,
                         S_SC0W = 4'd8, S_SCR = 4'd9, S_SCW = 4'd10, S_OUT = 4'd11,
                         S_SET0 = 4'd12;

  // configuration
  logic [6:0] side_q;
  logic [7:0] vcols_q, vrows_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 7'd64; vcols_q <= 8'd80; vrows_q <= 8'd24;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SIDE: side_q <= cfg_data_i[6:0];
        REG_COLS: vcols_q <= cfg_data_i;
        REG_ROWS: vrows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // derived geometry
  logic [SW-1:0] eside;
  logic [CW-1:0] rowc;
  logic [AW:0]   total;
  logic [AW+CW+SW:0] prod;
  always_comb begin
    if (side_q == 7'd0) eside = SW'(1);
    else if (32'(side_q) > MAX_SIDE) eside = SW'(MAX_SIDE);
    else eside = SW'(side_q);
    rowc = CW'((3 * 32'(eside) + 1) / 2);
    prod = (AW+CW+SW+1)'(rowc) * (AW+CW+SW+1)'(eside);
    if (prod > (AW+CW+SW+1)'(MAX_CELLS)) total = (AW+1)'(MAX_CELLS);
    else total = (AW+1)'(prod);
  end

  // memories
  logic [7:0] cmem [MAX_CELLS];
  logic       dmem [MAX_CELLS];
  logic [AW-1:0] raddr, waddr;
  logic          cwe, dwe;
  logic [7:0]    cwd, crd;
  logic          dwd, drd;
  always_ff @(posedge clk_i) begin
    if (cwe) cmem[waddr] <= cwd;
    crd <= cmem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (dwe) dmem[waddr] <= dwd;
    drd <= dmem[raddr];
  end

  logic [3:0]  st_q, st_d;
  logic [AW:0] ptr_q, ptr_d;
  logic [CW-1:0] col_q, col_d;
  logic [7:0]  row_q, row_d;
  logic [2:0]  op_q, op_d;
  logic [3:0]  ca_q, ca_d, cb_q, cb_d;
  logic        force_q, force_d;
  logic [PW-1:0] sub_q, sub_d;
  logic [1:0]  k_q, k_d;
  logic [AW+CW:0] ybase_q, ybase_d;
  logic [AW:0] sptr_q, sptr_d;
  logic [7:0]  lcol_q, lcol_d, lcolor_q, lcolor_d;
  logic [6:0]  lrow_q, lrow_d;
  logic        act_q, act_d;
  logic        ov_q, ov_d;
  logic [1:0]  rs_q, rs_d;
  logic [6:0]  rc_q, rc_d;
  logic [5:0]  rr_q, rr_d;
  logic [7:0]  rcl_q, rcl_d;
  logic        rj_q, rj_d, rx_q, rx_d;

  logic [AW+CW:0] sidx;
  logic [7:0] nib;
  logic       jump;
  assign sidx = ybase_q + (AW+CW+1)'(sub_q >> 1);
  assign in_ready_o = (st_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;

  always_comb begin
    st_d = st_q; ptr_d = ptr_q; col_d = col_q; row_d = row_q; op_d = op_q;
    ca_d = ca_q; cb_d = cb_q; force_d = force_q; sub_d = sub_q; k_d = k_q;
    ybase_d = ybase_q; sptr_d = sptr_q; lcol_d = lcol_q; lrow_d = lrow_q;
    lcolor_d = lcolor_q; act_d = act_q; ov_d = ov_q;
    rs_d = rs_q; rc_d = rc_q; rr_d = rr_q; rcl_d = rcl_q; rj_d = rj_q; rx_d = rx_q;
    raddr = ptr_q[AW-1:0]; waddr = ptr_q[AW-1:0];
    cwe = 1'b0; dwe = 1'b0; cwd = 8'd0; dwd = 1'b0;
    nib = 8'd0; jump = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      S_CLR: begin
        dwe = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == (AW+1)'(MAX_CELLS - 1)) begin
          st_d = S_IDLE; ptr_d = '0;
        end
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          op_d = opcode_i; ca_d = color_a_i; cb_d = color_b_i; force_d = force_all_i;
          rs_d = ST_DONE; rc_d = '0; rr_d = '0; rcl_d = '0; rj_d = 1'b0; rx_d = 1'b0;
          ptr_d = '0; col_d = '0; row_d = '0;
          sub_d = PW'(3) * PW'(pixel_x_i); k_d = 2'd0; ybase_d = '0;
          case (opcode_i)
            OP_SET: begin
              // row counts down while y*rowc is formed
              st_d = S_SET0; row_d = 8'(pixel_y_i);
            end
            OP_FILL, OP_CHECK: st_d = S_FILL;
            OP_REDRAW: st_d = S_RRD;
            OP_SCAN: begin
              if (!act_q) begin
                act_d = 1'b1; sptr_d = '0; lcol_d = 8'hff; lrow_d = 7'h7f;
                st_d = S_SC0;
              end else begin
                st_d = S_SCR;
              end
            end
            default: st_d = S_OUT;
          endcase
        end
      end
      S_SET0: begin // y*rowc by repeated add over y (y is at most 63)
        if (row_q == 8'd0) st_d = S_SRD;
        else begin
          ybase_d = ybase_q + (AW+CW+1)'(rowc); row_d = row_q - 1'b1;
        end
      end
      S_SRD: begin
        raddr = sidx[AW-1:0];
        if (sidx >= (AW+CW+1)'(total)) begin
          rs_d = ST_OVF; st_d = S_OUT;
        end else st_d = S_SWR;
      end
      S_SWR: begin
        waddr = sidx[AW-1:0];
        nib = sub_q[0] ? {ca_q, crd[3:0]} : {crd[7:4], ca_q};
        cwe = 1'b1; cwd = nib;
        if (nib != crd) begin dwe = 1'b1; dwd = 1'b1; end
        sub_d = sub_q + 1'b1; k_d = k_q + 1'b1;
        st_d = (k_q == 2'd2) ? S_OUT : S_SRD;
      end
      S_FILL: begin
        if (ptr_q >= total) st_d = S_OUT;
        else begin
          cwe = 1'b1; dwe = 1'b1; dwd = 1'b1;
          if (op_q == OP_FILL) cwd = {ca_q, ca_q};
          else cwd = row_q[0] ? {ca_q, cb_q} : {cb_q, ca_q};
          ptr_d = ptr_q + 1'b1;
          if (col_q == rowc - 1'b1) begin col_d = '0; row_d = row_q + 1'b1; end
          else col_d = col_q + 1'b1;
        end
      end
      S_RRD: begin
        if (ptr_q >= total) st_d = S_OUT;
        else st_d = S_RWR;
      end
      S_RWR: begin
        if (force_q || crd != 8'd0) begin dwe = 1'b1; dwd = 1'b1; end
        ptr_d = ptr_q + 1'b1; st_d = S_RRD;
      end
      S_SC0: begin raddr = '0; st_d = S_SC0W; end
      S_SC0W: begin lcolor_d = crd; st_d = S_SCR; ptr_d = '0; end
      S_SCR: begin
        // locate row/col of sptr by counting in ptr/col/row first
        if (ptr_q != sptr_q) begin
          ptr_d = ptr_q + 1'b1;
          if (col_q == rowc - 1'b1) begin col_d = '0; row_d = row_q + 1'b1; end
          else col_d = col_q + 1'b1;
        end else if (ptr_q >= total || row_q > vrows_q) begin
          act_d = 1'b0; sptr_d = '0; rs_d = ST_END; st_d = S_OUT;
        end else begin
          raddr = ptr_q[AW-1:0]; st_d = S_SCW;
        end
      end
      S_SCW: begin
        if (8'(col_q) < vcols_q && drd) begin
          dwe = 1'b1; dwd = 1'b0;
          sptr_d = ptr_q + 1'b1;
          rs_d = ST_CELL; rc_d = 7'(col_q); rr_d = row_q[5:0]; rcl_d = crd;
          jump = (lcol_q + 8'd1 != 8'(col_q)) || (lrow_q != row_q[6:0]) || row_q[7];
          rj_d = jump;
          if (jump) begin lcol_d = 8'(col_q); lrow_d = row_q[6:0]; end
          if (lcolor_q != crd) begin rx_d = 1'b1; lcolor_d = crd; end
          st_d = S_OUT;
        end else begin
          sptr_d = ptr_q + 1'b1; st_d = S_SCR;
        end
      end
      S_OUT: begin ov_d = 1'b1; st_d = S_IDLE; end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; ptr_q <= '0; sptr_q <= '0; act_q <= 1'b0; ov_q <= 1'b0;
      lcol_q <= 8'hff; lrow_q <= 7'h7f; lcolor_q <= 8'd0;
    end else begin
      st_q <= st_d; ptr_q <= ptr_d; sptr_q <= sptr_d; act_q <= act_d; ov_q <= ov_d;
      lcol_q <= lcol_d; lrow_q <= lrow_d; lcolor_q <= lcolor_d;
    end
  end
  always_ff @(posedge clk_i) begin
    col_q <= col_d; row_q <= row_d; op_q <= op_d; ca_q <= ca_d; cb_q <= cb_d;
    force_q <= force_d; sub_q <= sub_d; k_q <= k_d; ybase_q <= ybase_d;
    rs_q <= rs_d; rc_q <= rc_d; rr_q <= rr_d; rcl_q <= rcl_d; rj_q <= rj_d; rx_q <= rx_d;
  end

  assign status_o = rs_q;
  assign cell_col_o = rc_q;
  assign cell_row_o = rr_q;
  assign cell_color_o = rcl_q;
  assign cursor_jump_o = rj_q;
  assign color_change_o = rx_q;
endmodule
`default_nettype wire
